// ----- src/chhi_pkg.sv -----
// shared types, constants and the arctangent table for the compass heading block
// no dependencies
package chhi_pkg;

    localparam int ANGLE_FRAC = 20;
    localparam int TABLE_LEN  = 24;
    localparam int STEP_W     = 5;
    localparam int ATAN_W     = 27;
    localparam int X_W        = 36;
    localparam int Z_W        = 32;
    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_W    = 1;
    localparam int Q_CNT_W    = 2;

    typedef enum logic [1:0] {
        OP_CAL     = 2'd0,
        OP_LATCH   = 2'd1,
        OP_HEADING = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef struct packed {
        logic               heading;
        logic signed [15:0] dx;
        logic signed [15:0] dy;
        logic signed [15:0] off_x;
        logic signed [15:0] off_y;
        logic signed [15:0] off_z;
    } chhi_item_t;

    // round(atan(2^-i) * 2^20) in degrees
    function automatic logic [ATAN_W-1:0] atan_deg(input logic [STEP_W-1:0] i);
        logic [ATAN_W-1:0] v;
        case (i)
            5'd0:    v = 27'd47185920;
            5'd1:    v = 27'd27855475;
            5'd2:    v = 27'd14718068;
            5'd3:    v = 27'd7471121;
            5'd4:    v = 27'd3750058;
            5'd5:    v = 27'd1876857;
            5'd6:    v = 27'd938658;
            5'd7:    v = 27'd469357;
            5'd8:    v = 27'd234682;
            5'd9:    v = 27'd117342;
            5'd10:   v = 27'd58671;
            5'd11:   v = 27'd29335;
            5'd12:   v = 27'd14668;
            5'd13:   v = 27'd7334;
            5'd14:   v = 27'd3667;
            5'd15:   v = 27'd1833;
            5'd16:   v = 27'd917;
            5'd17:   v = 27'd458;
            5'd18:   v = 27'd229;
            5'd19:   v = 27'd115;
            5'd20:   v = 27'd57;
            5'd21:   v = 27'd29;
            5'd22:   v = 27'd14;
            5'd23:   v = 27'd7;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- src/chhi_front.sv -----
// front end: accepts items, tracks min/max and offsets, forms the queue entry
// depends on chhi_pkg
module chhi_front import chhi_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // raw_x, raw_y, raw_z
    input  logic [2:0]  s_tuser,   // operation, sample_ready
    input  logic        q_full,
    output logic        push,
    output chhi_item_t  push_item
);

    logic signed [15:0] max_reg  [3];
    logic signed [15:0] min_reg  [3];
    logic signed [15:0] off_reg  [3];
    logic signed [15:0] max_next [3];
    logic signed [15:0] min_next [3];
    logic signed [15:0] off_next [3];
    logic signed [15:0] smp      [3];
    logic signed [16:0] sum      [3];
    logic signed [16:0] half     [3];
    op_t                op;
    logic               rdy;

    assign s_tready = !q_full;
    assign push     = s_tvalid && s_tready;
    assign op       = op_t'(s_tuser[1:0]);
    assign rdy      = s_tuser[2];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            smp[a]      = rdy ? $signed(s_tdata[a*16 +: 16]) : 16'sd0;
            max_next[a] = max_reg[a];
            min_next[a] = min_reg[a];
            off_next[a] = off_reg[a];
            sum[a]      = {max_reg[a][15], max_reg[a]} + {min_reg[a][15], min_reg[a]};
            // halve, truncating toward zero
            half[a]     = sum[a][16] ? ((sum[a] + 17'sd1) >>> 1) : (sum[a] >>> 1);
            if (push && op == OP_CAL) begin
                if (smp[a] > max_reg[a]) max_next[a] = smp[a];
                if (smp[a] < min_reg[a]) min_next[a] = smp[a];
            end
            if (push && op == OP_LATCH) begin
                off_next[a] = half[a][15:0];
            end
        end
    end

    always_comb begin
        push_item.heading = (op == OP_HEADING);
        push_item.dx      = smp[0] - off_reg[0];
        push_item.dy      = smp[1] - off_reg[1];
        push_item.off_x   = off_next[0];
        push_item.off_y   = off_next[1];
        push_item.off_z   = off_next[2];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int a = 0; a < 3; a++) begin
                max_reg[a] <= -16'sd32768;
                min_reg[a] <= 16'sd32767;
                off_reg[a] <= '0;
            end
        end else begin
            for (int a = 0; a < 3; a++) begin
                max_reg[a] <= max_next[a];
                min_reg[a] <= min_next[a];
                off_reg[a] <= off_next[a];
            end
        end
    end

endmodule

// ----- src/chhi_queue.sv -----
// short queue between the front end and the heading unit
// depends on chhi_pkg
module chhi_queue import chhi_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  chhi_item_t         push_item,
    input  logic               pop,
    output logic               q_valid,
    output chhi_item_t         q_item,
    output logic               q_full,
    output logic [Q_CNT_W-1:0] q_count
);

    chhi_item_t         mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;
    logic [Q_CNT_W-1:0] count_next;

    assign q_valid = (count_reg != '0);
    assign q_full  = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign q_item  = mem_reg[rd_ptr_reg];
    assign q_count = count_reg;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) count_next = count_reg + 1'b1;
        if (!push && pop) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= push_item;
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

// ----- src/chhi_back.sv -----
// back end: iterative cordic heading unit and output register
// depends on chhi_pkg
module chhi_back import chhi_pkg::*; #(
    parameter int CORDIC_STEPS      = 16,
    parameter int HEADING_FRAC_BITS = 7
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    input  chhi_item_t  q_item,
    output logic        pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata    // heading_deg, offset_x_out, offset_y_out, offset_z_out
);

    localparam int NSTEPS = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
    localparam int SH     = ANGLE_FRAC - HEADING_FRAC_BITS;
    localparam logic [STEP_W-1:0] LAST = STEP_W'(NSTEPS - 1);
    localparam logic [Z_W-1:0]    HALF = Z_W'(1 << (SH - 1));
    localparam logic [Z_W-1:0]    FULL = Z_W'(360 << ANGLE_FRAC);
    localparam logic [Z_W-1:0]    LIM  = Z_W'(360 << HEADING_FRAC_BITS);
    localparam logic [Z_W-1:0]    HALF_TURN = Z_W'(180 << ANGLE_FRAC);

    typedef enum logic [1:0] {S_IDLE, S_ROT, S_DONE} state_t;

    state_t                state_reg;
    logic [STEP_W-1:0]     step_reg;
    logic signed [X_W-1:0] x_reg;
    logic signed [X_W-1:0] y_reg;
    logic signed [Z_W-1:0] z_reg;
    logic [47:0]           offs_reg;
    logic                  m_tvalid_reg;
    logic [63:0]           m_tdata_reg;

    logic                  out_free;
    logic                  out_load;
    logic                  zero_vec;
    logic signed [X_W-1:0] x0;
    logic signed [X_W-1:0] y0;
    logic signed [X_W-1:0] xs;
    logic signed [X_W-1:0] ys;
    logic signed [Z_W-1:0] ang;
    logic [Z_W-1:0]        zp;
    logic [Z_W-1:0]        r;
    logic [Z_W-1:0]        rw;

    assign out_free = !m_tvalid_reg || m_tready;
    assign pop      = (state_reg == S_IDLE) && q_valid && out_free;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign zero_vec = (q_item.dx == '0) && (q_item.dy == '0);
    assign out_load = (pop && !(q_item.heading && !zero_vec))
                   || ((state_reg == S_DONE) && out_free);
    assign x0 = $signed({{(X_W-32){q_item.dx[15]}}, q_item.dx, 16'h0000});
    assign y0 = $signed({{(X_W-32){q_item.dy[15]}}, q_item.dy, 16'h0000});

    assign xs  = x_reg >>> step_reg;
    assign ys  = y_reg >>> step_reg;
    assign ang = $signed(Z_W'(atan_deg(step_reg)));

    // wrap into a full turn, round half up, fold 360 to 0
    assign zp = z_reg[Z_W-1] ? (z_reg + FULL) : z_reg;
    assign r  = (zp + HALF) >> SH;
    assign rw = (r >= LIM) ? (r - LIM) : r;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            step_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= out_load || (m_tvalid_reg && !m_tready);
            case (state_reg)
                S_IDLE: begin
                    if (pop) begin
                        offs_reg <= {q_item.off_z, q_item.off_y, q_item.off_x};
                        if (q_item.heading && !zero_vec) begin
                            step_reg  <= '0;
                            state_reg <= S_ROT;
                            if (q_item.dx[15]) begin
                                x_reg <= -x0;
                                y_reg <= -y0;
                                z_reg <= $signed(HALF_TURN);
                            end else begin
                                x_reg <= x0;
                                y_reg <= y0;
                                z_reg <= '0;
                            end
                        end else begin
                            m_tdata_reg  <= {q_item.off_z, q_item.off_y, q_item.off_x, 16'h0000};
                        end
                    end
                end
                S_ROT: begin
                    if (y_reg > 0) begin
                        x_reg <= x_reg + ys;
                        y_reg <= y_reg - xs;
                        z_reg <= z_reg + ang;
                    end else begin
                        x_reg <= x_reg - ys;
                        y_reg <= y_reg + xs;
                        z_reg <= z_reg - ang;
                    end
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == LAST) state_reg <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        m_tdata_reg  <= {offs_reg, rw[15:0]};
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- src/compass_heading_hard_iron_calibrated_unit.sv -----
// compass heading with hard-iron calibration, top level
// calibrate, latch and other items: queue, then output register; one item per cycle while
// the output is not stalled and no heading is being rotated; heading items: queue, the steps
// of the single iterative cordic rotator, then output register; the rotator takes one item at a time
// reset: min/max to their extremes, offsets zero, queue and output empty
// depends on chhi_pkg, chhi_front, chhi_queue, chhi_back
module compass_heading_hard_iron_calibrated_unit import chhi_pkg::*; #(
    parameter int CORDIC_STEPS      = 16,
    parameter int HEADING_FRAC_BITS = 7
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // raw_x, raw_y, raw_z
    input  logic [2:0]  s_tuser,   // operation, sample_ready
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata    // heading_deg, offset_x_out, offset_y_out, offset_z_out
);

    logic               push;
    chhi_item_t         push_item;
    logic               pop;
    logic               q_valid;
    chhi_item_t         q_item;
    logic               q_full;
    logic [Q_CNT_W-1:0] q_count;

    chhi_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item)
    );

    chhi_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_full    (q_full),
        .q_count   (q_count)
    );

    chhi_back #(
        .CORDIC_STEPS      (CORDIC_STEPS),
        .HEADING_FRAC_BITS (HEADING_FRAC_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_count <= Q_CNT_W'(Q_DEPTH))
        else $error("queue count beyond depth");

    a_heading_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ({16'h0000, m_tdata[15:0]} < 32'(360 << HEADING_FRAC_BITS)))
        else $error("heading beyond a full turn");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (q_count == '0) && !m_tvalid)
        else $error("queue or output not empty after reset");

    a_pop_has_item: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> q_valid && !$isunknown(q_item.heading))
        else $error("pop from empty queue");

endmodule

// ----- test/tb_top.sv -----
// testbench for compass_heading_hard_iron_calibrated_unit: streams calibrate, latch, unused-code and
// heading items under random stalls and checks every result against a cordic predictor
// depends on chhi_pkg and the block's rtl
`timescale 1ns / 1ps

module tb_top;
    import chhi_pkg::*;

    localparam int STEPS     = 16;
    localparam int FRAC_BITS = 7;
    localparam int N_ITEMS   = 1750;

    typedef struct {
        int heading;
        int off_x;
        int off_y;
        int off_z;
    } reading_t;

    class heading_tracker;
        int max_x, min_x, max_y, min_y, max_z, min_z;
        int off_x, off_y, off_z;
        reading_t expected[$];
        int errors;

        function new();
            max_x = -32768; min_x = 32767;
            max_y = -32768; min_y = 32767;
            max_z = -32768; min_z = 32767;
            off_x = 0; off_y = 0; off_z = 0;
            errors = 0;
        endfunction

        function int cordic_heading(int dx, int dy);
            longint tab [24] = '{
                47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
                234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
                917, 458, 229, 115, 57, 29, 14, 7
            };
            longint x, y, z, xs, ys, r, lim;
            if (dx == 0 && dy == 0) return 0;
            x = longint'(dx) * 65536;
            y = longint'(dy) * 65536;
            z = 0;
            if (x < 0) begin
                x = -x;
                y = -y;
                z = longint'(180) << 20;
            end
            for (int i = 0; i < STEPS && i < 24; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (y > 0) begin
                    x += ys; y -= xs; z += tab[i];
                end else begin
                    x -= ys; y += xs; z -= tab[i];
                end
            end
            if (z < 0) z += longint'(360) << 20;
            r = (z + (longint'(1) << (20 - FRAC_BITS - 1))) >>> (20 - FRAC_BITS);
            lim = longint'(360) << FRAC_BITS;
            if (r >= lim) r -= lim;
            return int'(r);
        endfunction

        function void take_item(logic [2:0] user, logic [47:0] data);
            int x, y, z;
            logic signed [15:0] wx, wy;
            reading_t r;
            op_t op;
            op = op_t'(user[1:0]);
            x = user[2] ? int'($signed(data[15:0])) : 0;
            y = user[2] ? int'($signed(data[31:16])) : 0;
            z = user[2] ? int'($signed(data[47:32])) : 0;
            r.heading = 0;
            case (op)
                OP_CAL: begin
                    if (x > max_x) max_x = x;
                    if (x < min_x) min_x = x;
                    if (y > max_y) max_y = y;
                    if (y < min_y) min_y = y;
                    if (z > max_z) max_z = z;
                    if (z < min_z) min_z = z;
                end
                OP_LATCH: begin
                    off_x = (max_x + min_x) / 2;
                    off_y = (max_y + min_y) / 2;
                    off_z = (max_z + min_z) / 2;
                end
                OP_HEADING: begin
                    wx = 16'(x - off_x);
                    wy = 16'(y - off_y);
                    r.heading = cordic_heading(int'(wx), int'(wy));
                end
                default: ;
            endcase
            r.off_x = off_x;
            r.off_y = off_y;
            r.off_z = off_z;
            expected.push_back(r);
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [63:0] data);
            reading_t e;
            if (expected.size() == 0) begin
                $error("result with no item pending: %h", data);
                errors++;
                return;
            end
            e = expected.pop_front();
            compare_field("heading_deg", e.heading, int'(data[15:0]));
            compare_field("offset_x_out", e.off_x, int'($signed(data[31:16])));
            compare_field("offset_y_out", e.off_y, int'($signed(data[47:32])));
            compare_field("offset_z_out", e.off_z, int'($signed(data[63:48])));
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // raw_x, raw_y, raw_z
    logic [2:0]  s_tuser;   // operation, sample_ready
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;   // heading_deg, offset_x_out, offset_y_out, offset_z_out

    heading_tracker readings;
    int  sent;
    bit  sender_quiet;

    compass_heading_hard_iron_calibrated_unit #(
        .CORDIC_STEPS      (STEPS),
        .HEADING_FRAC_BITS (FRAC_BITS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) readings.take_item(s_tuser, s_tdata);
            if (m_tvalid && m_tready) readings.check_result(m_tdata);
        end
    end

    function int rnd_s16();
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    function int clamp16(int v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    task send_item(op_t op, bit rdy, int x, int y, int z);
        int gap;
        gap = sender_quiet ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= {rdy, op};
        s_tdata  <= {z[15:0], y[15:0], x[15:0]};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent++;
    endtask

    task wait_drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (readings.expected.size() != 0) @(posedge aclk);
    endtask

    task send_heading();
        int kind, mag, ox, oy;
        kind = $urandom_range(0, 11);
        ox = readings.off_x;
        oy = readings.off_y;
        mag = 1 << $urandom_range(0, 15);
        case (kind)
            0: send_item(OP_HEADING, 1'($urandom_range(0, 1)), rnd_s16(), rnd_s16(),
                         rnd_s16());
            1: send_item(OP_HEADING, 1'b1, ox, oy, rnd_s16());
            2: send_item(OP_HEADING, 1'b1, ox, oy + $urandom_range(0, 2 * mag) - mag,
                         rnd_s16());
            3: send_item(OP_HEADING, 1'b1, ox + $urandom_range(0, 2 * mag) - mag, oy,
                         rnd_s16());
            4: send_item(OP_HEADING, 1'b0, rnd_s16(), rnd_s16(), rnd_s16());
            5: send_item(OP_HEADING, 1'b1, ox + $urandom_range(0, 8) - 4,
                         oy + $urandom_range(0, 8) - 4, rnd_s16());
            6: send_item(OP_NONE, 1'($urandom_range(0, 1)), rnd_s16(), rnd_s16(), rnd_s16());
            default: send_item(OP_HEADING, 1'b1, ox + $urandom_range(0, 2 * mag) - mag,
                               oy + $urandom_range(0, 2 * mag) - mag, rnd_s16());
        endcase
    endtask

    // stalls on the result side, with quiet stretches
    initial begin
        int stall, left;
        bit quiet;
        left = 0;
        quiet = 1'b0;
        m_tready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (left == 0) begin
                quiet = ($urandom_range(0, 3) == 0);
                left = $urandom_range(8, 48);
            end
            left--;
            stall = quiet ? 0 : $urandom_range(0, 16);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    initial begin
        int phase, lim, sp, cx, cy, cz;
        readings = new();
        sent = 0;
        sender_quiet = 1'b0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser  <= '0;
        s_tdata  <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // latch with nothing calibrated, zero vectors, unused code, axis extremes
        send_item(OP_LATCH, 1'b1, rnd_s16(), rnd_s16(), rnd_s16());
        send_item(OP_HEADING, 1'b1, 0, 0, 0);
        send_item(OP_HEADING, 1'b0, -1, -1, -1);
        send_item(OP_NONE, 1'b1, 12345, -12345, 777);
        send_item(OP_HEADING, 1'b1, -32768, 0, 32767);
        send_item(OP_HEADING, 1'b1, 32767, 0, -32768);
        send_item(OP_HEADING, 1'b1, 0, 32767, 0);
        send_item(OP_HEADING, 1'b1, 0, -32768, 0);
        send_item(OP_HEADING, 1'b1, -32768, -32768, 0);
        send_item(OP_HEADING, 1'b1, 32767, -32768, 0);
        send_item(OP_HEADING, 1'b1, -1, -1, 0);
        send_item(OP_HEADING, 1'b1, 1, -1, 0);
        send_item(OP_HEADING, 1'b1, -1, 0, 0);
        send_item(OP_HEADING, 1'b1, 32767, -1, 0);
        send_item(OP_CAL, 1'b1, 32767, -32768, 32767);
        send_item(OP_CAL, 1'b1, 100, 200, -300);
        send_item(OP_CAL, 1'b0, -5000, 6000, -7000);
        send_item(OP_LATCH, 1'b0, 0, 0, 0);
        send_item(OP_HEADING, 1'b1, -32768, 32767, 0);
        send_item(OP_HEADING, 1'b1, 16383, -16284, 0);
        send_item(OP_NONE, 1'b0, 0, 0, 0);
        sender_quiet = 1'b1;
        send_item(OP_HEADING, 1'b1, 0, 0, 0);
        send_item(OP_LATCH, 1'b1, 0, 0, 0);

        // calibrate runs with a widening spread, then a latch, then headings
        phase = 0;
        while (sent < N_ITEMS) begin
            sender_quiet = ($urandom_range(0, 3) == 0);
            lim = (phase < 40) ? 200 + phase * 800 : 32767;
            cx = $urandom_range(0, 2 * lim) - lim;
            cy = $urandom_range(0, 2 * lim) - lim;
            cz = $urandom_range(0, 2 * lim) - lim;
            sp = $urandom_range(0, lim / 4 + 8);
            repeat ($urandom_range(2, 16)) begin
                if ($urandom_range(0, 11) == 0)
                    send_item(OP_CAL, 1'b0, rnd_s16(), rnd_s16(), rnd_s16());
                else if ($urandom_range(0, 11) == 0)
                    send_item(OP_NONE, 1'b1, rnd_s16(), rnd_s16(), rnd_s16());
                else
                    send_item(OP_CAL, 1'b1,
                              clamp16(cx + $urandom_range(0, 2 * sp) - sp),
                              clamp16(cy + $urandom_range(0, 2 * sp) - sp),
                              clamp16(cz + $urandom_range(0, 2 * sp) - sp));
            end
            if (phase == 0 || $urandom_range(0, 4) == 0) wait_drain();
            send_item(OP_LATCH, 1'($urandom_range(0, 1)), rnd_s16(), rnd_s16(), rnd_s16());
            repeat ($urandom_range(4, 24)) send_heading();
            phase++;
        end

        // full-scale calibration at the end
        send_item(OP_CAL, 1'b1, 32767, 32767, 32767);
        send_item(OP_CAL, 1'b1, -32768, -32768, -32768);
        send_item(OP_LATCH, 1'b1, 0, 0, 0);
        repeat (8) send_heading();
        s_tvalid <= 1'b0;

        wait_drain();
        repeat (40) @(posedge aclk);
        if (readings.errors == 0 && readings.expected.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #3000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- sim.f -----
src/chhi_pkg.sv
src/chhi_front.sv
src/chhi_queue.sv
src/chhi_back.sv
src/compass_heading_hard_iron_calibrated_unit.sv
test/tb_top.sv
